>>> rtl/limit_order_matcher_macros.svh
// Assertion macros shared by the limit order matcher RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LIMIT_ORDER_MATCHER_MACROS_SVH
`define LIMIT_ORDER_MATCHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LOM_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LOM_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

>>> rtl/lom_pkg.sv
// Types and codes of the limit order matcher.
// No dependencies; imported by every module of the block.
package lom_pkg;

   localparam logic [1:0] OP_BUY    = 2'd0;
   localparam logic [1:0] OP_SELL   = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_STATUS = 2'd3;

   localparam logic [2:0] KIND_POSTED      = 3'd0;
   localparam logic [2:0] KIND_REJECTED    = 3'd1;
   localparam logic [2:0] KIND_TRADE       = 3'd2;
   localparam logic [2:0] KIND_CANCELED    = 3'd3;
   localparam logic [2:0] KIND_CANCEL_FAIL = 3'd4;
   localparam logic [2:0] KIND_STATUS      = 3'd5;

   typedef struct packed {
      logic        is_sell;
      logic [31:0] id;
      logic [31:0] qty;
      logic [31:0] price;
   } entry_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] new_id;
      logic [31:0] buyer_id;
      logic [31:0] seller_id;
      logic [31:0] amount;
      logic [31:0] deal_price;
      logic [31:0] best_bid;
      logic [31:0] best_ask;
      logic [31:0] last_price;
      logic        last_of_run;
   } res_type;

   typedef struct packed {
      logic        is_sell;
      logic [31:0] px;
      logic [31:0] rem;
   } alu_req_type;

   typedef struct packed {
      logic        match;
      logic [31:0] fill;
      logic [31:0] ent_left;
      logic [31:0] rem_left;
      logic [31:0] deal;
   } alu_rsp_type;

endpackage

>>> rtl/lom_book.sv
// Order book storage: one write port and one registered read port.
// Depends on lom_pkg for the entry type.
module lom_book
   import lom_pkg::*;
#(
   parameter int BOOK_DEPTH = 32,
   localparam int IW = $clog2(BOOK_DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [IW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [BOOK_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (32'(rd_addr) < BOOK_DEPTH) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lom_alu.sv
// Shared match unit: price cross test, fill size and remainders for one entry.
// Depends on lom_pkg for the entry and request types.
module lom_alu
   import lom_pkg::*;
(
   input  entry_type   entry,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic px_cross;
   logic [31:0] fill;

   always_comb begin
      px_cross = req.is_sell ? (entry.price >= req.px) : (entry.price <= req.px);
      fill  = (entry.qty < req.rem) ? entry.qty : req.rem;
      rsp.match    = (entry.is_sell != req.is_sell) && px_cross && (req.rem != 32'd0);
      rsp.fill     = fill;
      rsp.ent_left = entry.qty - fill;
      rsp.rem_left = req.rem - fill;
      rsp.deal     = req.is_sell ? req.px : entry.price;
   end

endmodule

>>> rtl/limit_order_matcher.sv
// Limit order matcher top level: sequencer, price registers and result stage.
// An order or cancel walks the book once, one entry a cycle through the single
// book read port, held while a trade waits on a full output, then appends and
// flushes. Reject and status skip the walk. Synchronous reset empties the book.
module limit_order_matcher
   import lom_pkg::*;
#(
   parameter int BOOK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic        req_funds_ok,
   input  logic [31:0] req_quantity,
   input  logic [31:0] req_price,
   input  logic [31:0] req_order_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_new_id,
   output logic [31:0] rsp_buyer_id,
   output logic [31:0] rsp_seller_id,
   output logic [31:0] rsp_amount,
   output logic [31:0] rsp_deal_price,
   output logic [31:0] rsp_best_bid,
   output logic [31:0] rsp_best_ask,
   output logic [31:0] rsp_last_price,
   output logic        rsp_last_of_run
);

`include "limit_order_matcher_macros.svh"

   localparam int CW = $clog2(BOOK_DEPTH + 1);
   localparam int IW = $clog2(BOOK_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN, ST_FLUSH} state_type;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] px_ff, px_in, oid_ff, oid_in, id_ff, id_in, rem_ff, rem_in;
   logic [CW-1:0] i_ff, i_in, w_ff, w_in, count_ff, count_in;
   logic [31:0] ctr_ff, ctr_in, bid_ff, bid_in, ask_ff, ask_in, last_ff, last_in;
   res_type     pend_ff, pend_in, rsp_ff, rsp_in;
   logic        pend_v_ff, pend_v_in, rsp_valid_ff, rsp_valid_in;
   logic        found_ff, found_in;
   entry_type   hit_ff, hit_in;

   logic          out_free, push, flush;
   res_type       push_res;
   logic          wr_en;
   logic [CW-1:0] wr_ptr, rd_ptr;
   entry_type     wr_data, rd_data;
   alu_req_type   alu_req;
   alu_rsp_type   alu_rsp;
   logic [CW-1:0] i_next;
   logic [31:0]   ctr_next;

   function automatic res_type mk_res(input logic [2:0] kind, input logic [31:0] nid,
                                      input logic [31:0] buyer, input logic [31:0] seller,
                                      input logic [31:0] amt, input logic [31:0] dp,
                                      input logic [31:0] bid, input logic [31:0] ask,
                                      input logic [31:0] last);
      res_type r;
      r.kind        = kind;
      r.new_id      = nid;
      r.buyer_id    = buyer;
      r.seller_id   = seller;
      r.amount      = amt;
      r.deal_price  = dp;
      r.best_bid    = bid;
      r.best_ask    = ask;
      r.last_price  = last;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_book (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr[IW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_ptr[IW-1:0]),
      .rd_data (rd_data)
   );

   assign alu_req.is_sell = (op_ff == OP_SELL);
   assign alu_req.px      = px_ff;
   assign alu_req.rem     = rem_ff;

   lom_alu u_alu (
      .entry (rd_data),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign i_next   = i_ff + CW'(1);
   assign ctr_next = ctr_ff + 32'd1;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      px_in     = px_ff;
      oid_in    = oid_ff;
      id_in     = id_ff;
      rem_in    = rem_ff;
      i_in      = i_ff;
      w_in      = w_ff;
      count_in  = count_ff;
      ctr_in    = ctr_ff;
      bid_in    = bid_ff;
      ask_in    = ask_ff;
      last_in   = last_ff;
      found_in  = found_ff;
      hit_in    = hit_ff;
      push      = 1'b0;
      push_res  = pend_ff;
      flush     = 1'b0;
      wr_en     = 1'b0;
      wr_ptr    = w_ff;
      wr_data   = rd_data;
      rd_ptr    = '0;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               px_in    = req_price;
               oid_in   = req_order_id;
               rem_in   = req_quantity;
               i_in     = '0;
               w_in     = '0;
               found_in = 1'b0;
               push     = 1'b1;
               state_in = (count_ff == '0) ? ST_FIN : ST_WALK;
               case (req_op)
                  OP_BUY, OP_SELL: begin
                     ctr_in = ctr_next;
                     id_in  = ctr_next;
                     if (!req_funds_ok || count_ff >= DEPTH_C) begin
                        push_res = mk_res(KIND_REJECTED, '0, '0, '0, '0, '0,
                                          bid_ff, ask_ff, last_ff);
                        state_in = ST_FLUSH;
                     end else begin
                        if (req_op == OP_SELL) begin
                           if (ask_ff == '0 || req_price < ask_ff) begin
                              ask_in = req_price;
                           end
                           push_res = mk_res(KIND_POSTED, ctr_next, '0, ctr_next,
                                             req_quantity, req_price, bid_ff, ask_in,
                                             last_ff);
                        end else begin
                           if (req_price > bid_ff) begin
                              bid_in = req_price;
                           end
                           push_res = mk_res(KIND_POSTED, ctr_next, ctr_next, '0,
                                             req_quantity, req_price, bid_in, ask_ff,
                                             last_ff);
                        end
                     end
                  end
                  OP_CANCEL: begin
                     push = 1'b0;
                  end
                  default: begin
                     push_res = mk_res(KIND_STATUS, '0, '0, '0, '0, '0,
                                       bid_ff, ask_ff, last_ff);
                     state_in = ST_FLUSH;
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_ptr = i_next;
            if (op_ff == OP_CANCEL) begin
               if (!found_ff && rd_data.id == oid_ff) begin
                  found_in = 1'b1;
                  hit_in   = rd_data;
               end else begin
                  wr_en = 1'b1;
                  w_in  = w_ff + CW'(1);
               end
               i_in = i_next;
            end else if (alu_rsp.match) begin
               if (!pend_v_ff || out_free) begin
                  push     = 1'b1;
                  last_in  = alu_rsp.deal;
                  push_res = mk_res(KIND_TRADE, '0,
                                    alu_req.is_sell ? rd_data.id : id_ff,
                                    alu_req.is_sell ? id_ff : rd_data.id,
                                    alu_rsp.fill, alu_rsp.deal, bid_ff, ask_ff,
                                    alu_rsp.deal);
                  rem_in   = alu_rsp.rem_left;
                  wr_data.qty = alu_rsp.ent_left;
                  if (alu_rsp.ent_left != '0) begin
                     wr_en = 1'b1;
                     w_in  = w_ff + CW'(1);
                  end
                  i_in = i_next;
               end else begin
                  rd_ptr = i_ff;
               end
            end else begin
               wr_en = 1'b1;
               w_in  = w_ff + CW'(1);
               i_in  = i_next;
            end
            if (i_in == count_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_FLUSH;
            count_in = w_ff;
            if (op_ff == OP_CANCEL) begin
               push = 1'b1;
               if (found_ff) begin
                  push_res = mk_res(KIND_CANCELED, '0,
                                    hit_ff.is_sell ? '0 : hit_ff.id,
                                    hit_ff.is_sell ? hit_ff.id : '0,
                                    hit_ff.qty, '0, bid_ff, ask_ff, last_ff);
               end else begin
                  push_res = mk_res(KIND_CANCEL_FAIL, '0, '0, '0, '0, '0,
                                    bid_ff, ask_ff, last_ff);
               end
            end else if (rem_ff != '0) begin
               wr_en           = 1'b1;
               wr_data.is_sell = (op_ff == OP_SELL);
               wr_data.id      = id_ff;
               wr_data.qty     = rem_ff;
               wr_data.price   = px_ff;
               count_in        = w_ff + CW'(1);
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               flush    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      if (push) begin
         if (pend_v_ff) begin
            rsp_in       = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in   = push_res;
         pend_v_in = 1'b1;
      end else if (flush) begin
         rsp_in             = pend_ff;
         rsp_in.last_of_run = 1'b1;
         rsp_valid_in       = 1'b1;
         pend_v_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ctr_ff       <= '0;
         bid_ff       <= '0;
         ask_ff       <= '0;
         last_ff      <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ctr_ff       <= ctr_in;
         bid_ff       <= bid_in;
         ask_ff       <= ask_in;
         last_ff      <= last_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      op_ff   <= op_in;
      px_ff   <= px_in;
      oid_ff  <= oid_in;
      id_ff   <= id_in;
      rem_ff  <= rem_in;
      i_ff    <= i_in;
      w_ff    <= w_in;
      hit_ff  <= hit_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_new_id      = rsp_ff.new_id;
   assign rsp_buyer_id    = rsp_ff.buyer_id;
   assign rsp_seller_id   = rsp_ff.seller_id;
   assign rsp_amount      = rsp_ff.amount;
   assign rsp_deal_price  = rsp_ff.deal_price;
   assign rsp_best_bid    = rsp_ff.best_bid;
   assign rsp_best_ask    = rsp_ff.best_ask;
   assign rsp_last_price  = rsp_ff.last_price;
   assign rsp_last_of_run = rsp_ff.last_of_run;

   `LOM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `LOM_ASSERT_IMP(a_compact_order, clock, reset, state_ff == ST_WALK,
                   w_ff <= i_ff && i_ff < count_ff)
   `LOM_ASSERT_IMP(a_idle_empty, clock, reset, state_ff == ST_IDLE, !pend_v_ff)
   `LOM_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
                   !req_ready)

endmodule
